// File: sv/gwwb_pkg.sv
// ----------------------------------------------------------------------------
// gwwb_pkg
// Shared constants for the gray-world white balance statistics unit:
// luminance weights, register widths and indexes, reset values.
// ----------------------------------------------------------------------------
package gwwb_pkg;

	// Pixel samples and luminance weights (Q16, weights sum to 65536)
	localparam int unsigned SAMPLE_W = 16;
	localparam logic [15:0] W_R = 16'd19595;
	localparam logic [15:0] W_G = 16'd38470;
	localparam logic [15:0] W_B = 16'd7471;

	// Configuration register widths
	localparam int unsigned SB_W   = 5;
	localparam int unsigned FRAC_W = 16;
	localparam int unsigned FP_W   = 25;

	// Configuration port
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 25;

	localparam logic [CFG_IDX_W-1:0] REG_ENABLE       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_BITS  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_UNDER_FRAC   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OVER_FRAC    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_PIXELS = 3'd4;

	// Register reset values
	localparam logic             ENABLE_RST       = 1'b1;
	localparam logic [SB_W-1:0]  SAMPLE_BITS_RST  = 5'd12;
	localparam logic [FP_W-1:0]  FRAME_PIXELS_RST = 25'd2073600;

	// Sample depth clamp
	localparam logic [SB_W-1:0] SB_MIN = 5'd8;
	localparam logic [SB_W-1:0] SB_MAX = 5'd16;

	// Parameter defaults
	localparam int unsigned PIXEL_COUNT_BITS_DEF = 24;
	localparam int unsigned GAIN_FRAC_BITS_DEF   = 12;

endpackage

// File: sv/gray_world_white_balance_stats_unit.sv
// ----------------------------------------------------------------------------
// gray_world_white_balance_stats_unit
// Gray-world auto white balance statistics: passes RGB pixels through,
// accumulates in-range pixels and computes red/blue gains at frame end.
// ----------------------------------------------------------------------------
// A pixel accepted in S_IDLE runs through the multiply and accumulate steps
// and the window compare to S_OUT, where its result enters the output
// register; the next pixel can be taken in the cycle after, so a new pixel is
// never taken before the last one is through. On the last pixel of a frame the
// 1% floor, the channel checks and the two divisions come before S_OUT; a
// disabled or dark frame, or a gain too large for the divider, finishes sooner.
// A stalled, full output register holds the result in S_OUT. One shared
// multiplier forms the five products a pixel needs (three luminance terms and
// the two window bounds), each product registered before it is added, and on
// the frame's last pixel it also forms the 1% floor. The two gains come from
// one restoring divider that retires one quotient bit per cycle, red first,
// then blue. The input stalls while a pixel is in work; a result waits in the
// output register while the next pixel is taken. Configuration writes are
// always ready and must only be issued while no pixel is in work.

module gray_world_white_balance_stats_unit
	import gwwb_pkg::*;
#(
	parameter int unsigned PIXEL_COUNT_BITS = PIXEL_COUNT_BITS_DEF,
	parameter int unsigned GAIN_FRAC_BITS   = GAIN_FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,

	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [SAMPLE_W-1:0]         red,
	input  logic [SAMPLE_W-1:0]         green,
	input  logic [SAMPLE_W-1:0]         blue,

	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [SAMPLE_W-1:0]         red_out,
	output logic [SAMPLE_W-1:0]         green_out,
	output logic [SAMPLE_W-1:0]         blue_out,
	output logic                        frame_end,
	output logic [GAIN_FRAC_BITS+2:0]   red_gain,
	output logic [GAIN_FRAC_BITS+2:0]   blue_gain,

	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [CFG_DATA_W-1:0]       cfg_data
);

	localparam int unsigned CNT_W  = PIXEL_COUNT_BITS + 1;
	localparam int unsigned IDX_W  = PIXEL_COUNT_BITS;
	localparam int unsigned SUM_W  = PIXEL_COUNT_BITS + SAMPLE_W;
	localparam int unsigned HUND_W = SUM_W + 7;
	localparam int unsigned FL_W   = CNT_W + SAMPLE_W;
	localparam int unsigned MA_W   = (CNT_W > SAMPLE_W) ? CNT_W : SAMPLE_W;
	localparam int unsigned MB_W   = SAMPLE_W + 1;
	localparam int unsigned P_W    = MA_W + MB_W;
	localparam int unsigned LUM_W  = 32;
	localparam int unsigned Q_W    = GAIN_FRAC_BITS + 3;
	localparam int unsigned NUM_W  = SUM_W + GAIN_FRAC_BITS + 1;
	localparam int unsigned REM_W  = SUM_W + 1;
	localparam int unsigned CW     = $clog2(Q_W + 1);
	localparam int unsigned LEN_W  = (FP_W > CNT_W) ? FP_W : CNT_W;

	localparam logic [Q_W-1:0]   G_UNITY = Q_W'(1) << GAIN_FRAC_BITS;
	localparam logic [Q_W-1:0]   G_LO    = Q_W'(1) << (GAIN_FRAC_BITS - 2);
	localparam logic [Q_W-1:0]   G_HI    = Q_W'(1) << (GAIN_FRAC_BITS + 2);
	localparam logic [LEN_W-1:0] LEN_LIM = LEN_W'(1) << PIXEL_COUNT_BITS;

	typedef enum logic [3:0] {
		S_IDLE, S_MUL, S_ACC, S_CMP, S_HUND, S_CHK,
		S_DNUM, S_DCHK, S_DSTEP, S_DEND, S_FIN, S_OUT
	} state_t;

	typedef enum logic [2:0] {
		MS_LUM_R, MS_LUM_G, MS_LUM_B, MS_LOWER, MS_UPPER, MS_FLOOR
	} mstep_t;

	typedef enum logic [1:0] {
		CH_RED, CH_GREEN, CH_BLUE
	} chan_t;

	// Control and statistics
	state_t               state_q;
	mstep_t               step_q;
	chan_t                chan_q;
	logic                 last_q;
	logic [CW-1:0]        cnt_q;
	logic [SUM_W-1:0]     red_sum_q, green_sum_q, blue_sum_q;
	logic [CNT_W-1:0]     valid_count_q;
	logic [IDX_W-1:0]     pixel_index_q;
	logic [Q_W-1:0]       gain_red_q, gain_blue_q;

	// Configuration
	logic                 enable_q;
	logic [SB_W-1:0]      sample_bits_q;
	logic [FRAC_W-1:0]    under_q, over_q;
	logic [FP_W-1:0]      frame_pixels_q;

	// Output register
	logic                 out_valid_q;
	logic [SAMPLE_W-1:0]  red_out_q, green_out_q, blue_out_q;
	logic                 frame_end_q;
	logic [Q_W-1:0]       red_gain_q, blue_gain_q;

	// Datapath
	logic [SAMPLE_W-1:0]  r_q, g_q, b_q;
	logic [P_W-1:0]       prod_q;
	logic [LUM_W-1:0]     lum_q, lower_q, upper_q;
	logic [FL_W-1:0]      floor_q;
	logic [HUND_W-1:0]    hund_q;
	logic [NUM_W-1:0]     num_q;
	logic [SUM_W-1:0]     den_q, rem_q;
	logic [Q_W-1:0]       low_q, quo_q;

	// Combinational
	logic                 in_xfer, out_xfer, out_load;
	logic [SB_W-1:0]      bits_cl;
	logic [SAMPLE_W-1:0]  full;
	logic [MA_W-1:0]      mul_a;
	logic [MB_W-1:0]      mul_b;
	logic [LEN_W-1:0]     fp_ext, frame_len, idx_next;
	logic                 is_last, in_range;
	logic [SUM_W-1:0]     sum_sel;
	logic [SUM_W-1:0]     num_hi;
	logic [REM_W-1:0]     trial, trial_diff;
	logic                 trial_ge;
	logic [Q_W-1:0]       quo_cl;
	mstep_t               step_nxt;

	assign in_xfer   = in_valid && !in_stall;
	assign out_xfer  = out_valid_q && !out_stall;
	// load the output register when it is free or being drained
	assign out_load  = (state_q == S_OUT) && (!out_valid_q || !out_stall);
	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;

	assign out_valid = out_valid_q;
	assign red_out   = red_out_q;
	assign green_out = green_out_q;
	assign blue_out  = blue_out_q;
	assign frame_end = frame_end_q;
	assign red_gain  = red_gain_q;
	assign blue_gain = blue_gain_q;

	// Full scale from the clamped bit depth
	always_comb begin
		if (sample_bits_q < SB_MIN) begin
			bits_cl = SB_MIN;
		end else if (sample_bits_q > SB_MAX) begin
			bits_cl = SB_MAX;
		end else begin
			bits_cl = sample_bits_q;
		end
		full = {SAMPLE_W{1'b1}} >> (SB_MAX - bits_cl);
	end

	// Frame length and end-of-frame test
	always_comb begin
		fp_ext = LEN_W'(frame_pixels_q);
		if (fp_ext == '0) begin
			frame_len = LEN_W'(1);
		end else if (fp_ext > LEN_LIM) begin
			frame_len = LEN_LIM;
		end else begin
			frame_len = fp_ext;
		end
		idx_next = LEN_W'(pixel_index_q) + LEN_W'(1);
		is_last  = (idx_next >= frame_len);
		in_range = (lum_q >= lower_q) && (lum_q <= upper_q);
	end

	// Shared multiplier operands
	always_comb begin
		case (step_q)
			MS_LUM_R: begin
				mul_a = MA_W'(W_R);
				mul_b = MB_W'(r_q);
			end
			MS_LUM_G: begin
				mul_a = MA_W'(W_G);
				mul_b = MB_W'(g_q);
			end
			MS_LUM_B: begin
				mul_a = MA_W'(W_B);
				mul_b = MB_W'(b_q);
			end
			MS_LOWER: begin
				mul_a = MA_W'(full);
				mul_b = MB_W'(under_q);
			end
			MS_UPPER: begin
				mul_a = MA_W'(full);
				mul_b = (MB_W'(1) << FRAC_W) - MB_W'(over_q);
			end
			MS_FLOOR: begin
				mul_a = MA_W'(valid_count_q);
				mul_b = MB_W'(full);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		case (step_q)
			MS_LUM_R: step_nxt = MS_LUM_G;
			MS_LUM_G: step_nxt = MS_LUM_B;
			MS_LUM_B: step_nxt = MS_LOWER;
			MS_LOWER: step_nxt = MS_UPPER;
			default:  step_nxt = MS_LUM_R;
		endcase
	end

	always_comb begin
		case (chan_q)
			CH_RED:   sum_sel = red_sum_q;
			CH_GREEN: sum_sel = green_sum_q;
			CH_BLUE:  sum_sel = blue_sum_q;
			default:  sum_sel = '0;
		endcase
	end

	// Divider step: shift in the next dividend bit, subtract when it fits
	always_comb begin
		num_hi     = SUM_W'(num_q[NUM_W-1:Q_W]);
		trial      = {rem_q, low_q[Q_W-1]};
		trial_ge   = (trial >= REM_W'(den_q));
		trial_diff = trial - REM_W'(den_q);
		if (quo_q < G_LO) begin
			quo_cl = G_LO;
		end else if (quo_q > G_HI) begin
			quo_cl = G_HI;
		end else begin
			quo_cl = quo_q;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q       <= ENABLE_RST;
			sample_bits_q  <= SAMPLE_BITS_RST;
			under_q        <= '0;
			over_q         <= '0;
			frame_pixels_q <= FRAME_PIXELS_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ENABLE:       enable_q       <= cfg_data[0];
				REG_SAMPLE_BITS:  sample_bits_q  <= cfg_data[SB_W-1:0];
				REG_UNDER_FRAC:   under_q        <= cfg_data[FRAC_W-1:0];
				REG_OVER_FRAC:    over_q         <= cfg_data[FRAC_W-1:0];
				REG_FRAME_PIXELS: frame_pixels_q <= cfg_data[FP_W-1:0];
				default: ;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			r_q <= red;
			g_q <= green;
			b_q <= blue;
		end
		case (state_q)
			S_MUL: prod_q <= mul_a * mul_b;
			S_ACC: begin
				case (step_q)
					MS_LUM_R: lum_q   <= prod_q[LUM_W-1:0];
					MS_LUM_G: lum_q   <= lum_q + prod_q[LUM_W-1:0];
					MS_LUM_B: lum_q   <= lum_q + prod_q[LUM_W-1:0];
					MS_LOWER: lower_q <= prod_q[LUM_W-1:0];
					MS_UPPER: upper_q <= prod_q[LUM_W-1:0];
					MS_FLOOR: floor_q <= prod_q[FL_W-1:0];
					default: ;
				endcase
			end
			S_HUND: hund_q <= (HUND_W'(sum_sel) << 6) + (HUND_W'(sum_sel) << 5)
				+ (HUND_W'(sum_sel) << 2);
			S_DNUM: begin
				num_q <= (NUM_W'(green_sum_q) << GAIN_FRAC_BITS) + NUM_W'(sum_sel >> 1);
				den_q <= sum_sel;
			end
			S_DCHK: begin
				rem_q <= num_hi;
				low_q <= num_q[Q_W-1:0];
				if (num_hi >= den_q) begin
					quo_q <= G_HI;
				end else begin
					quo_q <= '0;
				end
			end
			S_DSTEP: begin
				low_q <= {low_q[Q_W-2:0], 1'b0};
				quo_q <= {quo_q[Q_W-2:0], trial_ge};
				if (trial_ge) begin
					rem_q <= trial_diff[SUM_W-1:0];
				end else begin
					rem_q <= trial[SUM_W-1:0];
				end
			end
			default: ;
		endcase
	end

	// Sequencer, statistics and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			step_q        <= MS_LUM_R;
			chan_q        <= CH_RED;
			last_q        <= 1'b0;
			cnt_q         <= '0;
			red_sum_q     <= '0;
			green_sum_q   <= '0;
			blue_sum_q    <= '0;
			valid_count_q <= '0;
			pixel_index_q <= '0;
			gain_red_q    <= G_UNITY;
			gain_blue_q   <= G_UNITY;
			out_valid_q   <= 1'b0;
			red_out_q     <= '0;
			green_out_q   <= '0;
			blue_out_q    <= '0;
			frame_end_q   <= 1'b0;
			red_gain_q    <= G_UNITY;
			blue_gain_q   <= G_UNITY;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_xfer) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						step_q  <= MS_LUM_R;
						state_q <= S_MUL;
					end
				end
				S_MUL: state_q <= S_ACC;
				S_ACC: begin
					if (step_q == MS_UPPER) begin
						state_q <= S_CMP;
					end else if (step_q == MS_FLOOR) begin
						gain_red_q  <= G_UNITY;
						gain_blue_q <= G_UNITY;
						chan_q      <= CH_RED;
						if (!enable_q || valid_count_q == '0) begin
							state_q <= S_FIN;
						end else begin
							state_q <= S_HUND;
						end
					end else begin
						step_q  <= step_nxt;
						state_q <= S_MUL;
					end
				end
				S_CMP: begin
					if (in_range) begin
						red_sum_q     <= red_sum_q + SUM_W'(r_q);
						green_sum_q   <= green_sum_q + SUM_W'(g_q);
						blue_sum_q    <= blue_sum_q + SUM_W'(b_q);
						valid_count_q <= valid_count_q + CNT_W'(1);
					end
					last_q <= is_last;
					if (is_last) begin
						pixel_index_q <= '0;
						step_q        <= MS_FLOOR;
						state_q       <= S_MUL;
					end else begin
						pixel_index_q <= pixel_index_q + IDX_W'(1);
						state_q       <= S_OUT;
					end
				end
				S_HUND: state_q <= S_CHK;
				S_CHK: begin
					// any channel at or below 1% of full scale keeps unity gains
					if (hund_q <= HUND_W'(floor_q)) begin
						state_q <= S_FIN;
					end else if (chan_q == CH_BLUE) begin
						chan_q  <= CH_RED;
						state_q <= S_DNUM;
					end else begin
						chan_q  <= (chan_q == CH_RED) ? CH_GREEN : CH_BLUE;
						state_q <= S_HUND;
					end
				end
				S_DNUM: state_q <= S_DCHK;
				S_DCHK: begin
					cnt_q <= CW'(Q_W);
					if (num_hi >= den_q) begin
						state_q <= S_DEND;
					end else begin
						state_q <= S_DSTEP;
					end
				end
				S_DSTEP: begin
					cnt_q <= cnt_q - CW'(1);
					if (cnt_q == CW'(1)) begin
						state_q <= S_DEND;
					end
				end
				S_DEND: begin
					if (chan_q == CH_RED) begin
						gain_red_q <= quo_cl;
						chan_q     <= CH_BLUE;
						state_q    <= S_DNUM;
					end else begin
						gain_blue_q <= quo_cl;
						state_q     <= S_FIN;
					end
				end
				S_FIN: begin
					red_sum_q     <= '0;
					green_sum_q   <= '0;
					blue_sum_q    <= '0;
					valid_count_q <= '0;
					state_q       <= S_OUT;
				end
				S_OUT: begin
					// hold until the output register is free or being drained
					if (out_load) begin
						red_out_q   <= r_q;
						green_out_q <= g_q;
						blue_out_q  <= b_q;
						frame_end_q <= last_q;
						red_gain_q  <= gain_red_q;
						blue_gain_q <= gain_blue_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_gain_range: assert property (@(posedge clk) disable iff (!arst_n)
		(gain_red_q >= G_LO) && (gain_red_q <= G_HI)
		&& (gain_blue_q >= G_LO) && (gain_blue_q <= G_HI))
		else $error("latched gain outside clamp range");

	a_index_bound: assert property (@(posedge clk) disable iff (!arst_n)
		LEN_W'(pixel_index_q) < LEN_LIM)
		else $error("pixel index beyond frame limit");

	a_frame_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && last_q) |-> (valid_count_q == '0) && (red_sum_q == '0)
		&& (green_sum_q == '0) && (blue_sum_q == '0) && (pixel_index_q == '0))
		else $error("statistics not cleared at frame end");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DSTEP) |-> (rem_q < den_q))
		else $error("divider remainder not below divisor");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> in_stall)
		else $error("input taken while a pixel is in work");
`endif

endmodule
